// ===== rtl/rdp_pkg.sv =====
`default_nettype none
package rdp_pkg;

  localparam int ADDR_FIELD_W      = 32;
  localparam int DIST_W            = 6;
  localparam int DIST_MAX          = 63;
  localparam int STACK_DEPTH_DEF   = 64;
  localparam int ADDR_WIDTH_DEF    = 32;

  // progress of one item through the chain
  typedef struct packed {
    logic              v;
    logic              done;
    logic              found;
    logic [DIST_W-1:0] distance;
  } rdp_flow_t;

endpackage
`default_nettype wire

// ===== rtl/rdp_in_if.sv =====
`default_nettype none
interface rdp_in_if;
  import rdp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ADDR_FIELD_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface
`default_nettype wire

// ===== rtl/rdp_out_if.sv =====
`default_nettype none
interface rdp_out_if;
  import rdp_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [DIST_W-1:0] distance;

  modport source (output valid, output found, output distance, input ready);
  modport sink   (input valid, input found, input distance, output ready);
endinterface
`default_nettype wire

// ===== rtl/reuse_distance_profiler.sv =====
`default_nettype none
// channel   dir  handshake       payload
// in_ch     in   valid/ready     address[31:0]
// out_ch    out  valid/ready     found, distance[5:0]
//
// Systolic LRU stack: while the chain advances, an item passes one cell per
// cycle and then the output register, and one item may be accepted every cycle.
// Synchronous active-low reset empties the stack (fill count to zero).
// The chain advances when the output register can take the last cell's item
// or that cell is empty; a waiting result stalls it only if that cell is full.
module reuse_distance_profiler #(
  parameter int STACK_DEPTH = rdp_pkg::STACK_DEPTH_DEF,
  parameter int ADDR_WIDTH  = rdp_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rdp_in_if.sink    in_ch,
  rdp_out_if.source out_ch
);
  import rdp_pkg::*;

  localparam int FILL_W = $clog2(STACK_DEPTH + 1);

  rdp_flow_t             flow   [STACK_DEPTH+1];
  logic [ADDR_WIDTH-1:0] tag    [STACK_DEPTH+1];
  logic [ADDR_WIDTH-1:0] carry  [STACK_DEPTH+1];
  logic [STACK_DEPTH-1:0] grow;

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              advance;
  logic              out_v_r;
  logic              out_found_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [ADDR_WIDTH-1:0] in_tag;
  rdp_flow_t         flow_in;

  generate
    if (ADDR_WIDTH <= ADDR_FIELD_W) begin : g_tag_narrow
      assign in_tag = in_ch.address[ADDR_WIDTH-1:0];
    end else begin : g_tag_wide
      assign in_tag = {{(ADDR_WIDTH-ADDR_FIELD_W){1'b0}}, in_ch.address};
    end
  endgenerate

  assign advance     = out_ch.ready || !out_v_r || !flow[STACK_DEPTH].v;
  assign in_ch.ready = advance;

  always_comb begin
    flow_in   = '0;
    flow_in.v = in_ch.valid;
  end

  assign flow[0]  = flow_in;
  assign tag[0]   = in_tag;
  assign carry[0] = in_tag;

  genvar i;
  generate
    for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
      rdp_cell #(
        .IDX        (i),
        .ADDR_WIDTH (ADDR_WIDTH)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .frontier (fill_r == FILL_W'(i)),
        .flow_i   (flow[i]),
        .tag_i    (tag[i]),
        .carry_i  (carry[i]),
        .flow_o   (flow[i+1]),
        .tag_o    (tag[i+1]),
        .carry_o  (carry[i+1]),
        .grow     (grow[i])
      );
    end
  endgenerate

  assign fill_nxt = (|grow) ? fill_r + FILL_W'(1) : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (advance && (out_ch.ready || !out_v_r)) begin
        out_v_r <= flow[STACK_DEPTH].v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (out_ch.ready || !out_v_r)) begin
      out_found_r <= flow[STACK_DEPTH].found;
      out_dist_r  <= flow[STACK_DEPTH].distance;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.distance = out_dist_r;
endmodule
`default_nettype wire

// ===== rtl/rdp_cell.sv =====
`default_nettype none
module rdp_cell #(
  parameter int IDX        = 0,
  parameter int ADDR_WIDTH = rdp_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  advance,
  input  wire logic                  frontier,
  input  wire rdp_pkg::rdp_flow_t    flow_i,
  input  wire logic [ADDR_WIDTH-1:0] tag_i,
  input  wire logic [ADDR_WIDTH-1:0] carry_i,
  output rdp_pkg::rdp_flow_t         flow_o,
  output logic      [ADDR_WIDTH-1:0] tag_o,
  output logic      [ADDR_WIDTH-1:0] carry_o,
  output logic                       grow
);
  import rdp_pkg::*;

  localparam logic [DIST_W-1:0] CELL_DIST =
    (IDX > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(IDX);

  logic [ADDR_WIDTH-1:0] held_r, held_nxt;
  rdp_flow_t             flow_r, flow_nxt;
  logic [ADDR_WIDTH-1:0] tag_r, carry_r, carry_nxt;
  logic                  proc;

  assign proc = flow_i.v && !flow_i.done;
  assign grow = advance && proc && frontier;

  always_comb begin
    flow_nxt  = flow_i;
    held_nxt  = held_r;
    carry_nxt = held_r;
    if (proc) begin
      held_nxt = carry_i;
      if (frontier) begin
        // first write of this entry: miss, push ends here
        flow_nxt.done     = 1'b1;
        flow_nxt.found    = 1'b0;
        flow_nxt.distance = '0;
      end else if (held_r == tag_i) begin
        flow_nxt.done     = 1'b1;
        flow_nxt.found    = 1'b1;
        flow_nxt.distance = CELL_DIST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_r.v <= 1'b0;
    end else if (advance) begin
      flow_r.v <= flow_nxt.v;
    end
    if (advance) begin
      held_r          <= held_nxt;
      flow_r.done     <= flow_nxt.done;
      flow_r.found    <= flow_nxt.found;
      flow_r.distance <= flow_nxt.distance;
      tag_r           <= tag_i;
      carry_r         <= carry_nxt;
    end
  end

  assign flow_o  = flow_r;
  assign tag_o   = tag_r;
  assign carry_o = carry_r;
endmodule
`default_nettype wire
